/* rtl/core/vpd_record_keyword_parser_assert.svh */
// ----------------------------------------------------------------------------
// vpd record keyword parser assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef VPD_RECORD_KEYWORD_PARSER_ASSERT_SVH
`define VPD_RECORD_KEYWORD_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VPD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vpd parser assertion failed");
`define VPD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vpd parser reset assertion failed");
`else
`define VPD_ASSERT(label, clk, rstn, prop)
`define VPD_ASSERT_RST(label, clk, prop)
`endif
`endif

/* rtl/core/vpd_kwp_pkg.sv */
// ----------------------------------------------------------------------------
// vpd_kwp_pkg
// types and constants of the vpd record keyword parser
// ----------------------------------------------------------------------------
`default_nettype none

package vpd_kwp_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_ALL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KEYWORD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_NAME = 2'd2;

    localparam logic [1:0] EV_VALUE = 2'd0;
    localparam logic [1:0] EV_EMPTY = 2'd1;
    localparam logic [1:0] EV_END = 2'd2;
    localparam logic [1:0] EV_MISMATCH = 2'd3;

    localparam logic [15:0] KW_END = 16'h5046;
    localparam logic [7:0] POUND_CHAR = 8'h23;

    localparam logic [3:0] HEADER_LAST = 4'd2;
    localparam logic [3:0] NAME_FIRST = 4'd6;
    localparam logic [3:0] NAME_LAST = 4'd9;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_PREFIX  = 8'b0000_0010,
        PH_NAME_HI = 8'b0000_0100,
        PH_NAME_LO = 8'b0000_1000,
        PH_LEN_LO  = 8'b0001_0000,
        PH_LEN_HI  = 8'b0010_0000,
        PH_DATA    = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

endpackage

`default_nettype wire

/* rtl/core/vpd_record_keyword_parser.sv */
// ----------------------------------------------------------------------------
// vpd_record_keyword_parser
// byte-serial keyword parser for one vital-product-data record
// ----------------------------------------------------------------------------
// a result is registered and shown on the master side in the cycle after its input transaction
// throughput: 1 byte per cycle while the sink keeps up, set by the single parser state update
// the result register frees a slot whenever the sink takes it
// reset: synchronous active-low aresetn, parser idle until a record start,
// config, index, name and length registers cleared to zero, phase set to PH_IDLE, no result pending
`default_nettype none

module vpd_record_keyword_parser (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [vpd_kwp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vpd_kwp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // data_byte
    input  wire logic                                s_tuser,  // record_start
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [23:0]                              m_tdata,  // keyword_name, value_byte
    output logic [1:0]                               m_tuser,  // event_kind
    output logic                                     m_tlast   // value_last
);

    logic        list_reg;
    logic [15:0] target_reg;
    logic [31:0] exp_name_reg;

    vpd_kwp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] name_reg, name_next;
    logic [15:0] len_reg, len_next;
    logic        mism_reg, mism_next;

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [15:0] m_name_reg;
    logic [7:0]  m_byte_reg;
    logic        m_last_reg;

    logic        s_fire;
    logic        emit;
    logic [1:0]  ev_kind;
    logic [15:0] ev_name;
    logic [7:0]  ev_byte;
    logic        ev_last;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_reg <= 1'b0;
            target_reg <= '0;
            exp_name_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vpd_kwp_pkg::CFG_LIST_ALL_MODE: list_reg <= cfg_wdata[0];
                vpd_kwp_pkg::CFG_TARGET_KEYWORD: target_reg <= cfg_wdata[15:0];
                vpd_kwp_pkg::CFG_EXPECTED_NAME: exp_name_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [1:0]  sh;
        logic [7:0]  want;
        logic [15:0] len_new;
        logic        sel;
        logic        match_done;
        logic        last;

        sh = 2'(vpd_kwp_pkg::NAME_LAST - idx_reg);
        want = exp_name_reg[{sh, 3'b000} +: 8];
        sel = list_reg || (name_reg == target_reg);
        match_done = !list_reg && (name_reg == target_reg);
        len_new = '0;
        last = (len_reg == 16'd1);

        phase_next = phase_reg;
        idx_next = idx_reg;
        name_next = name_reg;
        len_next = len_reg;
        mism_next = mism_reg;
        emit = 1'b0;
        ev_kind = vpd_kwp_pkg::EV_VALUE;
        ev_name = '0;
        ev_byte = '0;
        ev_last = 1'b0;

        if (s_fire) begin
            if (s_tuser) begin
                phase_next = vpd_kwp_pkg::PH_PREFIX;
                idx_next = 4'd1;
                name_next = '0;
                len_next = '0;
                mism_next = 1'b0;
            end else begin
                unique case (phase_reg)
                    vpd_kwp_pkg::PH_PREFIX: begin
                        if (idx_reg >= vpd_kwp_pkg::NAME_FIRST &&
                            idx_reg <= vpd_kwp_pkg::NAME_LAST && want != s_tdata) begin
                            mism_next = 1'b1;
                        end
                        if (idx_reg == vpd_kwp_pkg::HEADER_LAST && list_reg) begin
                            phase_next = vpd_kwp_pkg::PH_NAME_HI;
                        end else if (idx_reg >= vpd_kwp_pkg::NAME_LAST) begin
                            if (mism_next) begin
                                phase_next = vpd_kwp_pkg::PH_DONE;
                                emit = 1'b1;
                                ev_kind = vpd_kwp_pkg::EV_MISMATCH;
                            end else begin
                                phase_next = vpd_kwp_pkg::PH_NAME_HI;
                            end
                        end else begin
                            idx_next = idx_reg + 4'd1;
                        end
                    end
                    vpd_kwp_pkg::PH_NAME_HI: begin
                        name_next = {s_tdata, 8'h00};
                        phase_next = vpd_kwp_pkg::PH_NAME_LO;
                    end
                    vpd_kwp_pkg::PH_NAME_LO: begin
                        name_next = {name_reg[15:8], s_tdata};
                        if (name_next == vpd_kwp_pkg::KW_END) begin
                            phase_next = vpd_kwp_pkg::PH_DONE;
                            emit = 1'b1;
                            ev_kind = vpd_kwp_pkg::EV_END;
                            ev_name = vpd_kwp_pkg::KW_END;
                        end else begin
                            phase_next = vpd_kwp_pkg::PH_LEN_LO;
                        end
                    end
                    vpd_kwp_pkg::PH_LEN_LO, vpd_kwp_pkg::PH_LEN_HI: begin
                        if (phase_reg == vpd_kwp_pkg::PH_LEN_LO) begin
                            len_new = {8'h00, s_tdata};
                        end else begin
                            len_new = {s_tdata, len_reg[7:0]};
                        end
                        len_next = len_new;
                        if (phase_reg == vpd_kwp_pkg::PH_LEN_LO &&
                            name_reg[15:8] == vpd_kwp_pkg::POUND_CHAR) begin
                            phase_next = vpd_kwp_pkg::PH_LEN_HI;
                        end else if (len_new == '0) begin
                            emit = sel;
                            ev_kind = vpd_kwp_pkg::EV_EMPTY;
                            ev_name = name_reg;
                            phase_next = match_done ? vpd_kwp_pkg::PH_DONE
                                                    : vpd_kwp_pkg::PH_NAME_HI;
                        end else begin
                            phase_next = vpd_kwp_pkg::PH_DATA;
                        end
                    end
                    vpd_kwp_pkg::PH_DATA: begin
                        len_next = len_reg - 16'd1;
                        if (last) begin
                            phase_next = match_done ? vpd_kwp_pkg::PH_DONE
                                                    : vpd_kwp_pkg::PH_NAME_HI;
                        end
                        emit = sel;
                        ev_kind = vpd_kwp_pkg::EV_VALUE;
                        ev_name = name_reg;
                        ev_byte = s_tdata;
                        ev_last = last;
                    end
                    vpd_kwp_pkg::PH_IDLE, vpd_kwp_pkg::PH_DONE: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= vpd_kwp_pkg::PH_IDLE;
            idx_reg <= '0;
            name_reg <= '0;
            len_reg <= '0;
            mism_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            idx_reg <= idx_next;
            name_reg <= name_next;
            len_reg <= len_next;
            mism_reg <= mism_next;
            if (s_fire) begin
                m_valid_reg <= emit;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            m_kind_reg <= ev_kind;
            m_name_reg <= ev_name;
            m_byte_reg <= ev_byte;
            m_last_reg <= ev_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser = m_kind_reg;
    assign m_tdata = {m_byte_reg, m_name_reg};
    assign m_tlast = m_last_reg;

`include "vpd_record_keyword_parser_assert.svh"

    `VPD_ASSERT(a_start_restarts, aclk, aresetn, s_tvalid && s_tready && s_tuser |=> phase_reg == vpd_kwp_pkg::PH_PREFIX && idx_reg == 4'd1)
    `VPD_ASSERT(a_status_clean, aclk, aresetn, m_tvalid && m_tuser != vpd_kwp_pkg::EV_VALUE |-> m_tdata[23:16] == 8'h00 && !m_tlast)
    `VPD_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

`default_nettype wire
